// ----- rtl/core/sfs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package sfs_pkg;

    localparam int CHANNELS_DEF    = 4;
    localparam int TABLE_DEPTH_DEF = 256;

    // host masks carry this many channel bits
    localparam int MASK_BITS = 4;

    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_BIND   = 3'd1;
    localparam logic [2:0] OP_UNBIND = 3'd2;
    localparam logic [2:0] OP_TAKE   = 3'd3;
    localparam logic [2:0] OP_QUERY  = 3'd4;
    localparam logic [2:0] OP_LOAD   = 3'd5;

    localparam logic KIND_PRESENT = 1'b0;
    localparam logic KIND_REPLY   = 1'b1;

    localparam int FLAG_ACTIVE   = 0;
    localparam int FLAG_STARTED  = 1;
    localparam int FLAG_COMPLETE = 2;
    localparam int FLAG_INTR     = 3;

    typedef struct packed {
        logic [2:0]  operation;
        logic [2:0]  battler;
        logic [7:0]  frame_base;
        logic [7:0]  frame_count;
        logic        repeat_req;
        logic [7:0]  table_address;
        logic [15:0] duration_value;
        logic [3:0]  can_present_mask;
        logic [3:0]  stage_ok_mask;
    } in_word_t;

    typedef struct packed {
        logic       kind;
        logic [2:0] out_battler;
        logic [7:0] frame_address;
        logic       display_slot;
        logic       accepted;
        logic       done_res;
        logic       presenting;
        logic       was_interrupted;
        logic       last;
    } out_word_t;

    typedef struct packed {
        logic [7:0]  base;
        logic [7:0]  length;
        logic        loops;
        logic [15:0] ticks;
        logic [7:0]  frame;
        logic        slot;
        logic [3:0]  flags;
    } chan_t;

    // channels past the mask width are never permitted
    function automatic logic mask_bit(input logic [3:0] mask, input logic [3:0] ch);
        logic hit;
        hit = 1'b0;
        if (ch < 4'(MASK_BITS))
        begin
            hit = mask[ch[1:0]];
        end
        return hit;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/sfs_stream_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface sfs_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/sprite_frame_sequencer.sv -----
`timescale 1ns / 1ps
`default_nettype none

// frame animation sequencer for up to CHANNELS display channels sharing one duration
// table of TABLE_DEPTH entries; every word on items is one command (tick, bind,
// unbind, take interrupted flag, query, load duration) and the block takes one command
// at a time: ready is high only while the sequencer is idle. a non-tick command is
// accepted, applied in S_OP and answered in S_REPLY with one reply word. a tick walks
// the channels one after another through a single evaluation step: an idle, held or
// counting channel is handled in S_EVAL alone, a channel that stages a frame goes on
// through S_ADDR, which subtracts TABLE_DEPTH while folding its table address into
// range (no subtraction at a depth of 256), and S_DUR, because its duration comes out
// of the registered-read table memory; S_FLUSH closes the tick. present words of a tick
// are held back by one so the final one can carry last; a tick with the host detached
// returns nothing. results sit in an output register, so a stalled sink only slows
// a tick when a held present word must go out behind the waiting one. the user writes
// host_attached through cfg_we / cfg_wdata while the block is idle; the block does not
// enforce this. durations read from never-loaded table entries are undefined

module sprite_frame_sequencer #(
    parameter int CHANNELS    = sfs_pkg::CHANNELS_DEF,
    parameter int TABLE_DEPTH = sfs_pkg::TABLE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    sfs_stream_if.sink   items,
    sfs_stream_if.source results
);

    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNT_W = $clog2(CHANNELS + 1);
    localparam int TA_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [8:0]       DEPTH9  = 9'(TABLE_DEPTH);
    localparam logic [CNT_W-1:0] CH_END  = CNT_W'(CHANNELS);

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_OP    = 3'd1;  // apply a non-tick command
    localparam logic [2:0] S_REPLY = 3'd2;  // send the reply word
    localparam logic [2:0] S_EVAL  = 3'd3;  // evaluate one channel of a tick
    localparam logic [2:0] S_ADDR  = 3'd4;  // fold table address, then read
    localparam logic [2:0] S_DUR   = 3'd5;  // duration ready, commit staging
    localparam logic [2:0] S_FLUSH = 3'd6;  // push held present word with last

    logic [2:0]  state_reg, state_next;
    logic        host_reg;

    sfs_pkg::in_word_t  word_reg, word_next;
    logic [CNT_W-1:0]   ch_cnt_reg, ch_cnt_next;
    logic [7:0]         idx_reg, idx_next;
    logic               slot_reg, slot_next;
    logic [7:0]         addr_reg, addr_next;
    logic [7:0]         mod_reg, mod_next;
    logic               acc_reg, acc_next;
    logic               took_reg, took_next;
    logic               taken_reg, taken_next;

    // held present word of the running tick
    sfs_pkg::out_word_t pend_reg, pend_next;
    logic               pend_valid_reg, pend_valid_next;

    // output register
    sfs_pkg::out_word_t out_reg, out_word;
    logic               out_valid_reg, out_valid_next;
    logic               out_load;
    logic               out_free;

    // per-channel state, read and written at one selected channel
    sfs_pkg::chan_t     chan_reg [CHANNELS];
    sfs_pkg::chan_t     cur;
    sfs_pkg::chan_t     chan_wdata;
    logic               chan_we;
    logic [CH_W-1:0]    sel_idx;

    logic               in_accept;
    logic               battler_ok;
    logic               perm;
    logic               ok;
    logic               stage_go;
    logic [7:0]         stage_idx;
    logic               stage_slot;
    logic [7:0]         nxt_frame;

    // duration table
    logic               ram_we;
    logic               ram_re;
    logic [TA_W-1:0]    ram_waddr;
    logic [TA_W-1:0]    ram_raddr;
    logic [15:0]        ram_rdata;

    sfs_ram #(
        .WIDTH (16),
        .DEPTH (TABLE_DEPTH)
    ) u_dur_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (word_reg.duration_value),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign items.ready   = (state_reg == S_IDLE);
    assign in_accept     = items.valid && items.ready;
    assign results.valid = out_valid_reg;
    assign results.data  = out_reg;
    assign out_free      = !out_valid_reg || results.ready;

    assign battler_ok = (4'(word_reg.battler) < 4'(CHANNELS));
    assign ram_waddr  = word_reg.table_address[TA_W-1:0];
    assign ram_raddr  = mod_reg[TA_W-1:0];

    // tick states address the walking channel, commands address battler
    always_comb
    begin
        if (state_reg == S_EVAL || state_reg == S_DUR)
        begin
            sel_idx = ch_cnt_reg[CH_W-1:0];
        end
        else
        begin
            sel_idx = word_reg.battler[CH_W-1:0];
        end
    end

    assign cur  = chan_reg[sel_idx];
    assign perm = sfs_pkg::mask_bit(word_reg.can_present_mask, 4'(ch_cnt_reg));
    assign ok   = sfs_pkg::mask_bit(word_reg.stage_ok_mask, 4'(ch_cnt_reg));
    assign nxt_frame = cur.frame + 8'd1;

    always_comb
    begin
        state_next      = state_reg;
        word_next       = word_reg;
        ch_cnt_next     = ch_cnt_reg;
        idx_next        = idx_reg;
        slot_next       = slot_reg;
        addr_next       = addr_reg;
        mod_next        = mod_reg;
        acc_next        = acc_reg;
        took_next       = took_reg;
        taken_next      = taken_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_load        = 1'b0;
        out_word        = pend_reg;
        chan_we         = 1'b0;
        chan_wdata      = cur;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        stage_go        = 1'b0;
        stage_idx       = 8'd0;
        stage_slot      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    word_next = items.data;
                    if (items.data.operation == sfs_pkg::OP_TICK)
                    begin
                        // detached host: tick has no effect
                        if (host_reg)
                        begin
                            ch_cnt_next = '0;
                            state_next  = S_EVAL;
                        end
                    end
                    else
                    begin
                        state_next = S_OP;
                    end
                end
            end

            S_OP:
            begin
                acc_next   = 1'b0;
                took_next  = 1'b0;
                taken_next = 1'b0;
                case (word_reg.operation)
                    sfs_pkg::OP_BIND:
                    begin
                        if (host_reg && word_reg.frame_count != 8'd0 && battler_ok)
                        begin
                            chan_we        = 1'b1;
                            chan_wdata     = '0;
                            chan_wdata.base   = word_reg.frame_base;
                            chan_wdata.length = word_reg.frame_count;
                            chan_wdata.loops  = word_reg.repeat_req;
                            chan_wdata.flags[sfs_pkg::FLAG_ACTIVE] = 1'b1;
                            acc_next = 1'b1;
                        end
                    end
                    sfs_pkg::OP_UNBIND:
                    begin
                        if (battler_ok)
                        begin
                            chan_we    = 1'b1;
                            chan_wdata = '0;
                            acc_next   = 1'b1;
                        end
                    end
                    sfs_pkg::OP_TAKE:
                    begin
                        if (battler_ok)
                        begin
                            chan_we    = 1'b1;
                            chan_wdata.flags[sfs_pkg::FLAG_INTR] = 1'b0;
                            taken_next = cur.flags[sfs_pkg::FLAG_INTR];
                            took_next  = 1'b1;
                            acc_next   = 1'b1;
                        end
                    end
                    sfs_pkg::OP_QUERY:
                    begin
                        acc_next = battler_ok;
                    end
                    sfs_pkg::OP_LOAD:
                    begin
                        if ({1'b0, word_reg.table_address} < DEPTH9)
                        begin
                            ram_we   = 1'b1;
                            acc_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        acc_next = 1'b0;
                    end
                endcase
                state_next = S_REPLY;
            end

            S_REPLY:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    out_word = '0;
                    out_word.kind        = sfs_pkg::KIND_REPLY;
                    out_word.out_battler = word_reg.battler;
                    out_word.accepted    = acc_reg;
                    if (battler_ok)
                    begin
                        out_word.done_res   = cur.flags[sfs_pkg::FLAG_COMPLETE];
                        out_word.presenting = host_reg
                            && cur.flags[sfs_pkg::FLAG_ACTIVE]
                            && cur.flags[sfs_pkg::FLAG_STARTED]
                            && sfs_pkg::mask_bit(word_reg.can_present_mask,
                                                 4'(word_reg.battler));
                        out_word.was_interrupted = took_reg ? taken_reg
                                                 : cur.flags[sfs_pkg::FLAG_INTR];
                    end
                    out_word.last = 1'b1;
                    state_next    = S_IDLE;
                end
            end

            S_EVAL:
            begin
                if (ch_cnt_reg == CH_END)
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    if (!cur.flags[sfs_pkg::FLAG_ACTIVE])
                    begin
                        stage_go = 1'b0;
                    end
                    else if (!perm)
                    begin
                        // host withdrew permission: drop a started animation
                        if (cur.flags[sfs_pkg::FLAG_STARTED])
                        begin
                            chan_we    = 1'b1;
                            chan_wdata = '0;
                            chan_wdata.flags[sfs_pkg::FLAG_INTR] = 1'b1;
                        end
                    end
                    else if (!cur.flags[sfs_pkg::FLAG_STARTED])
                    begin
                        stage_go = 1'b1;
                    end
                    else if (cur.flags[sfs_pkg::FLAG_COMPLETE])
                    begin
                        stage_go = 1'b0;
                    end
                    else if (cur.ticks > 16'd1)
                    begin
                        chan_we          = 1'b1;
                        chan_wdata.ticks = cur.ticks - 16'd1;
                    end
                    else if (nxt_frame >= cur.length)
                    begin
                        if (cur.loops)
                        begin
                            stage_go   = 1'b1;
                            stage_slot = ~cur.slot;
                        end
                        else
                        begin
                            // last frame held, animation done
                            chan_we          = 1'b1;
                            chan_wdata.ticks = 16'd1;
                            chan_wdata.flags[sfs_pkg::FLAG_COMPLETE] = 1'b1;
                        end
                    end
                    else
                    begin
                        stage_go   = 1'b1;
                        stage_idx  = nxt_frame;
                        stage_slot = ~cur.slot;
                    end

                    // failed staging leaves the channel untouched
                    if (stage_go && stage_idx < cur.length && ok)
                    begin
                        idx_next   = stage_idx;
                        slot_next  = stage_slot;
                        addr_next  = cur.base + stage_idx;
                        mod_next   = cur.base + stage_idx;
                        state_next = S_ADDR;
                    end
                    else
                    begin
                        ch_cnt_next = ch_cnt_reg + CNT_W'(1);
                    end
                end
            end

            S_ADDR:
            begin
                if ({1'b0, mod_reg} >= DEPTH9)
                begin
                    mod_next = 8'({1'b0, mod_reg} - DEPTH9);
                end
                else
                begin
                    ram_re     = 1'b1;
                    state_next = S_DUR;
                end
            end

            S_DUR:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    chan_we          = 1'b1;
                    chan_wdata.frame = idx_reg;
                    chan_wdata.slot  = slot_reg;
                    chan_wdata.ticks = (ram_rdata == 16'd0) ? 16'd1 : ram_rdata;
                    chan_wdata.flags[sfs_pkg::FLAG_STARTED]  = 1'b1;
                    chan_wdata.flags[sfs_pkg::FLAG_COMPLETE] = 1'b0;
                    // the previous present word is known not to be last
                    if (pend_valid_reg)
                    begin
                        out_load = 1'b1;
                        out_word = pend_reg;
                    end
                    pend_next = '0;
                    pend_next.kind          = sfs_pkg::KIND_PRESENT;
                    pend_next.out_battler   = 3'(ch_cnt_reg);
                    pend_next.frame_address = addr_reg;
                    pend_next.display_slot  = slot_reg;
                    pend_valid_next = 1'b1;
                    ch_cnt_next     = ch_cnt_reg + CNT_W'(1);
                    state_next      = S_EVAL;
                end
            end

            S_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    out_load        = 1'b1;
                    out_word        = pend_reg;
                    out_word.last   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = out_load || (out_valid_reg && !results.ready);

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            host_reg       <= 1'b0;
            ch_cnt_reg     <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                chan_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            ch_cnt_reg     <= ch_cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                host_reg <= cfg_wdata;
            end
            if (chan_we)
            begin
                chan_reg[sel_idx] <= chan_wdata;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        word_reg  <= word_next;
        idx_reg   <= idx_next;
        slot_reg  <= slot_next;
        addr_reg  <= addr_next;
        mod_reg   <= mod_next;
        acc_reg   <= acc_next;
        took_reg  <= took_next;
        taken_reg <= taken_next;
        pend_reg  <= pend_next;
        if (out_load)
        begin
            out_reg <= out_word;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/sfs_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sfs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/core/sfs_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sfs_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_ready,
    input  wire logic [2:0]         in_op,
    input  wire logic               out_valid,
    input  wire logic               out_ready,
    input  wire sfs_pkg::out_word_t out_word
);

    // a reply always closes its command
    a_reply_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_word.kind == sfs_pkg::KIND_REPLY) |-> out_word.last)
        else $error("reply word without last");

    // present words carry no reply status
    a_present_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_word.kind == sfs_pkg::KIND_PRESENT) |->
        (!out_word.accepted && !out_word.done_res && !out_word.presenting
         && !out_word.was_interrupted))
        else $error("present word with reply status");

    // a command keeps the block busy until its reply is built
    a_cmd_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_op != sfs_pkg::OP_TICK) |=> !in_ready)
        else $error("ready right after a command word");

    // a waiting word is not withdrawn
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result word dropped while stalled");

endmodule

bind sprite_frame_sequencer sfs_checker u_sfs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (items.valid),
    .in_ready  (items.ready),
    .in_op     (items.data.operation),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_word  (results.data)
);

`default_nettype wire

// ----- verif/sprite_frame_sequencer_test.sv -----
`timescale 1ns / 1ps

module sprite_frame_sequencer_test;
    import sfs_pkg::*;

    localparam int CHANNELS      = 4;
    localparam int TABLE_DEPTH   = 256;
    localparam int RANDOM_ITEMS  = 260;
    // settling wait, after every owed word is back, before the sender goes on
    localparam int SETTLE_CYCLES = 40;
    localparam int IN_BITS       = $bits(in_word_t);

    // operation codes the block does not know
    localparam logic [2:0] OP_BAD_LO = 3'd6;
    localparam logic [2:0] OP_BAD_HI = 3'd7;

    // receiver stall patterns
    localparam int READY_ALWAYS   = 0;
    localparam int READY_COIN     = 1;
    localparam int READY_SPARSE   = 2;
    localparam int READY_PERIODIC = 3;

    // one step of the directed plan: either a host setting or a command word,
    // optionally with its reply typed in by hand
    typedef struct {
        bit        set_host;
        logic      host_val;
        in_word_t  cmd;
        bit        typed;
        out_word_t want;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    sfs_stream_if #(.T(in_word_t))  items_if ();
    sfs_stream_if #(.T(out_word_t)) results_if ();

    sprite_frame_sequencer #(
        .CHANNELS    (CHANNELS),
        .TABLE_DEPTH (TABLE_DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .items     (items_if),
        .results   (results_if)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // shadow of the sequencer state
    // ------------------------------------------------------------------
    chan_t       chan_state   [CHANNELS];
    logic [15:0] frame_ticks  [TABLE_DEPTH];
    bit          frame_loaded [TABLE_DEPTH];
    logic        host_on;

    // words produced by the command being applied, then the words still owed
    out_word_t   command_words [$];
    out_word_t   owed_words    [$];

    int failures       = 0;
    int items_sent     = 0;
    int random_items   = 0;
    int presents_seen  = 0;
    int replies_seen   = 0;
    int host_writes    = 0;
    int bursts_left    = 0;

    out_word_t want_word;
    out_word_t got_word;
    bit        word_bad;

    // wipe a channel's binding; the interrupted flag may survive
    function automatic void drop_channel(int ch, bit keep_intr);
        logic keep;
        keep = keep_intr & chan_state[ch].flags[FLAG_INTR];
        chan_state[ch] = '0;
        chan_state[ch].flags[FLAG_INTR] = keep;
    endfunction

    // show frame idx of a channel in the given slot, if the host staging works
    function automatic void stage_frame(int ch, logic [7:0] idx, logic slot, logic [3:0] ok);
        logic [7:0]  addr;
        logic [15:0] dur;
        out_word_t   r;
        if (idx >= chan_state[ch].length || !ok[ch])
        begin
            return;
        end
        addr = chan_state[ch].base + idx;
        dur  = frame_ticks[addr];
        chan_state[ch].frame = idx;
        chan_state[ch].slot  = slot;
        // a zero duration still holds the frame for one tick
        chan_state[ch].ticks = (dur != 16'd0) ? dur : 16'd1;
        chan_state[ch].flags[FLAG_STARTED]  = 1'b1;
        chan_state[ch].flags[FLAG_COMPLETE] = 1'b0;
        r = '0;
        r.kind          = KIND_PRESENT;
        r.out_battler   = 3'(ch);
        r.frame_address = addr;
        r.display_slot  = slot;
        command_words.push_back(r);
    endfunction

    // one tick walks the channels in order
    function automatic void run_tick(logic [3:0] can, logic [3:0] ok);
        logic [7:0] nxt;
        if (!host_on)
        begin
            return;
        end
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            if (!chan_state[ch].flags[FLAG_ACTIVE])
            begin
                continue;
            end
            // host withdrew permission: a running animation is dropped
            if (!can[ch])
            begin
                if (chan_state[ch].flags[FLAG_STARTED])
                begin
                    drop_channel(ch, 1'b1);
                    chan_state[ch].flags[FLAG_INTR] = 1'b1;
                end
                continue;
            end
            if (!chan_state[ch].flags[FLAG_STARTED])
            begin
                stage_frame(ch, 8'd0, 1'b0, ok);
                continue;
            end
            if (chan_state[ch].flags[FLAG_COMPLETE])
            begin
                continue;
            end
            if (chan_state[ch].ticks > 16'd1)
            begin
                chan_state[ch].ticks = chan_state[ch].ticks - 16'd1;
                continue;
            end
            nxt = chan_state[ch].frame + 8'd1;
            if (nxt >= chan_state[ch].length)
            begin
                // one-shot animation holds its last frame
                if (!chan_state[ch].loops)
                begin
                    chan_state[ch].flags[FLAG_COMPLETE] = 1'b1;
                    chan_state[ch].ticks = 16'd1;
                    continue;
                end
                nxt = 8'd0;
            end
            stage_frame(ch, nxt, ~chan_state[ch].slot, ok);
        end
    endfunction

    // apply one command word to the shadow state, filling command_words
    function automatic void apply_command(in_word_t w);
        out_word_t r;
        bit        valid_ch;
        bit        took;
        logic      taken;
        int        ch;
        command_words.delete();
        ch       = w.battler;
        valid_ch = (w.battler < CHANNELS);
        took     = 1'b0;
        taken    = 1'b0;
        r        = '0;
        if (w.operation == OP_TICK)
        begin
            run_tick(w.can_present_mask, w.stage_ok_mask);
            // final present word of the tick carries last
            if (command_words.size() > 0)
            begin
                r = command_words.pop_back();
                r.last = 1'b1;
                command_words.push_back(r);
            end
            return;
        end
        case (w.operation)
            OP_BIND:
            begin
                if (host_on && w.frame_count != 8'd0 && valid_ch)
                begin
                    drop_channel(ch, 1'b0);
                    chan_state[ch].base   = w.frame_base;
                    chan_state[ch].length = w.frame_count;
                    chan_state[ch].loops  = w.repeat_req;
                    chan_state[ch].flags[FLAG_ACTIVE] = 1'b1;
                    r.accepted = 1'b1;
                end
            end
            OP_UNBIND:
            begin
                if (valid_ch)
                begin
                    drop_channel(ch, 1'b0);
                    r.accepted = 1'b1;
                end
            end
            OP_TAKE:
            begin
                if (valid_ch)
                begin
                    taken = chan_state[ch].flags[FLAG_INTR];
                    chan_state[ch].flags[FLAG_INTR] = 1'b0;
                    took = 1'b1;
                    r.accepted = 1'b1;
                end
            end
            OP_QUERY:
            begin
                r.accepted = valid_ch;
            end
            OP_LOAD:
            begin
                // every 8-bit address is inside a 256-deep table
                frame_ticks[w.table_address]  = w.duration_value;
                frame_loaded[w.table_address] = 1'b1;
                r.accepted = 1'b1;
            end
            default:
            begin
            end
        endcase
        r.kind        = KIND_REPLY;
        r.out_battler = w.battler;
        r.last        = 1'b1;
        // status reflects the channel after the command
        if (valid_ch)
        begin
            r.done_res   = chan_state[ch].flags[FLAG_COMPLETE];
            r.presenting = host_on && chan_state[ch].flags[FLAG_ACTIVE]
                           && chan_state[ch].flags[FLAG_STARTED] && w.can_present_mask[ch];
            r.was_interrupted = took ? taken : chan_state[ch].flags[FLAG_INTR];
        end
        command_words.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // command word builders
    // ------------------------------------------------------------------
    function automatic in_word_t simple_cmd(logic [2:0] op, logic [2:0] ch, logic [3:0] can);
        in_word_t w;
        w = '0;
        w.operation        = op;
        w.battler          = ch;
        w.can_present_mask = can;
        return w;
    endfunction

    function automatic in_word_t bind_cmd(logic [2:0] ch, logic [7:0] base, logic [7:0] count,
                                          logic rep);
        in_word_t w;
        w = simple_cmd(OP_BIND, ch, 4'h0);
        w.frame_base  = base;
        w.frame_count = count;
        w.repeat_req  = rep;
        return w;
    endfunction

    function automatic in_word_t load_cmd(logic [7:0] addr, logic [15:0] dur);
        in_word_t w;
        w = simple_cmd(OP_LOAD, 3'd0, 4'h0);
        w.table_address  = addr;
        w.duration_value = dur;
        return w;
    endfunction

    function automatic in_word_t tick_cmd(logic [3:0] can, logic [3:0] ok);
        in_word_t w;
        w = simple_cmd(OP_TICK, 3'd0, can);
        w.stage_ok_mask = ok;
        return w;
    endfunction

    function automatic out_word_t reply_of(logic [2:0] ch, logic acc, logic done, logic pres,
                                           logic intr);
        out_word_t r;
        r = '0;
        r.kind            = KIND_REPLY;
        r.out_battler     = ch;
        r.accepted        = acc;
        r.done_res        = done;
        r.presenting      = pres;
        r.was_interrupted = intr;
        r.last            = 1'b1;
        return r;
    endfunction

    function automatic plan_row_t cmd_row(in_word_t w);
        plan_row_t p;
        p.set_host = 1'b0;
        p.host_val = 1'b0;
        p.cmd      = w;
        p.typed    = 1'b0;
        p.want     = '0;
        return p;
    endfunction

    function automatic plan_row_t checked_row(in_word_t w, out_word_t want);
        plan_row_t p;
        p = cmd_row(w);
        p.typed = 1'b1;
        p.want  = want;
        return p;
    endfunction

    function automatic plan_row_t host_row(logic v);
        plan_row_t p;
        p = cmd_row('0);
        p.set_host = 1'b1;
        p.host_val = v;
        return p;
    endfunction

    // ------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------

    // hand one command word over, log what it owes, then maybe idle
    task automatic issue(in_word_t w, bit typed, out_word_t want);
        items_if.valid <= 1'b1;
        items_if.data  <= w;
        do
            @(posedge clk);
        while (!(items_if.valid === 1'b1 && items_if.ready === 1'b1));
        items_sent++;
        apply_command(w);
        if (typed)
        begin
            owed_words.push_back(want);
        end
        else
        begin
            while (command_words.size() > 0)
            begin
                owed_words.push_back(command_words.pop_front());
            end
        end
        // bursts of back-to-back words, separated by short gaps
        if (bursts_left > 0)
        begin
            bursts_left--;
        end
        else
        begin
            items_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            bursts_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(0, 8);
        end
    endtask

    // hold the sender until every owed word is back and the block has settled
    task automatic drain_results();
        items_if.valid <= 1'b0;
        while (owed_words.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_host(logic v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        host_on = v;
        host_writes++;
    endtask

    // load every table entry a bind may read that was never written
    task automatic ensure_loaded(logic [7:0] base, logic [7:0] count);
        logic [7:0]  addr;
        logic [15:0] dur;
        for (int i = 0; i < count; i++)
        begin
            addr = base + 8'(i);
            if (!frame_loaded[addr])
            begin
                dur = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 65535))
                                                  : 16'($urandom_range(0, 3));
                issue(load_cmd(addr, dur), 1'b0, '0);
                random_items++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // receiver side: stall pattern changes every so often
    // ------------------------------------------------------------------
    initial
    begin : stall_pattern
        int mode;
        int mode_left;
        mode      = READY_ALWAYS;
        mode_left = 0;
        results_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (mode_left == 0)
            begin
                mode      = $urandom_range(READY_ALWAYS, READY_PERIODIC);
                mode_left = $urandom_range(30, 150);
            end
            mode_left--;
            case (mode)
                READY_ALWAYS:   results_if.ready <= 1'b1;
                READY_COIN:     results_if.ready <= 1'($urandom_range(0, 1));
                READY_SPARSE:   results_if.ready <= ($urandom_range(0, 3) == 0);
                default:        results_if.ready <= ((mode_left % 5) != 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // result checking: each accepted word against the oldest owed one
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && results_if.valid === 1'b1 && results_if.ready === 1'b1)
        begin
            got_word = results_if.data;
            if (got_word.kind == KIND_PRESENT)
            begin
                presents_seen++;
            end
            else
            begin
                replies_seen++;
            end
            if (owed_words.size() == 0)
            begin
                $error("result word with nothing owed: %h", got_word);
                failures++;
            end
            else
            begin
                want_word = owed_words.pop_front();
                word_bad  = 1'b0;
                if (got_word.kind !== want_word.kind)
                begin
                    $error("kind: expected %0d, got %0d", want_word.kind, got_word.kind);
                    word_bad = 1'b1;
                end
                if (got_word.out_battler !== want_word.out_battler)
                begin
                    $error("out_battler: expected %0d, got %0d",
                           want_word.out_battler, got_word.out_battler);
                    word_bad = 1'b1;
                end
                if (got_word.frame_address !== want_word.frame_address)
                begin
                    $error("frame_address: expected %0d, got %0d",
                           want_word.frame_address, got_word.frame_address);
                    word_bad = 1'b1;
                end
                if (got_word.display_slot !== want_word.display_slot)
                begin
                    $error("display_slot: expected %0d, got %0d",
                           want_word.display_slot, got_word.display_slot);
                    word_bad = 1'b1;
                end
                if (got_word.accepted !== want_word.accepted)
                begin
                    $error("accepted: expected %0d, got %0d",
                           want_word.accepted, got_word.accepted);
                    word_bad = 1'b1;
                end
                if (got_word.done_res !== want_word.done_res)
                begin
                    $error("done_res: expected %0d, got %0d",
                           want_word.done_res, got_word.done_res);
                    word_bad = 1'b1;
                end
                if (got_word.presenting !== want_word.presenting)
                begin
                    $error("presenting: expected %0d, got %0d",
                           want_word.presenting, got_word.presenting);
                    word_bad = 1'b1;
                end
                if (got_word.was_interrupted !== want_word.was_interrupted)
                begin
                    $error("was_interrupted: expected %0d, got %0d",
                           want_word.was_interrupted, got_word.was_interrupted);
                    word_bad = 1'b1;
                end
                if (got_word.last !== want_word.last)
                begin
                    $error("last: expected %0d, got %0d", want_word.last, got_word.last);
                    word_bad = 1'b1;
                end
                if (word_bad)
                begin
                    failures++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        plan_row_t   plan [$];
        plan_row_t   cur;
        in_word_t    w;
        int          roll;
        logic [7:0]  count;
        logic [2:0]  ch;

        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_wdata      <= 1'b0;
        items_if.valid <= 1'b0;
        items_if.data  <= '0;
        host_on = 1'b0;
        for (int i = 0; i < CHANNELS; i++)
        begin
            chan_state[i] = '0;
        end
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            frame_loaded[i] = 1'b0;
            frame_ticks[i]  = 16'd0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // host detached after reset: queries answer, binds fail, ticks stay silent
        plan.push_back(checked_row(simple_cmd(OP_QUERY, 3'd0, 4'hF),
                                   reply_of(3'd0, 1'b1, 1'b0, 1'b0, 1'b0)));
        plan.push_back(checked_row(bind_cmd(3'd0, 8'd0, 8'd3, 1'b0),
                                   reply_of(3'd0, 1'b0, 1'b0, 1'b0, 1'b0)));
        plan.push_back(cmd_row(tick_cmd(4'hF, 4'hF)));
        // unknown operations only reply with accepted low
        plan.push_back(checked_row(simple_cmd(OP_BAD_LO, 3'd7, 4'hF),
                                   reply_of(3'd7, 1'b0, 1'b0, 1'b0, 1'b0)));
        plan.push_back(checked_row(simple_cmd(OP_BAD_HI, 3'd2, 4'hF),
                                   reply_of(3'd2, 1'b0, 1'b0, 1'b0, 1'b0)));
        plan.push_back(host_row(1'b1));
        // table extremes: zero duration, full duration at the top address
        plan.push_back(checked_row(load_cmd(8'd0, 16'd0),
                                   reply_of(3'd0, 1'b1, 1'b0, 1'b0, 1'b0)));
        plan.push_back(checked_row(load_cmd(8'd255, 16'hFFFF),
                                   reply_of(3'd0, 1'b1, 1'b0, 1'b0, 1'b0)));
        plan.push_back(checked_row(load_cmd(8'd1, 16'd2),
                                   reply_of(3'd0, 1'b1, 1'b0, 1'b0, 1'b0)));
        plan.push_back(checked_row(load_cmd(8'd2, 16'd1),
                                   reply_of(3'd0, 1'b1, 1'b0, 1'b0, 1'b0)));
        plan.push_back(cmd_row(bind_cmd(3'd0, 8'd0, 8'd3, 1'b0)));
        // looping animation whose addresses wrap past the top of the table
        plan.push_back(cmd_row(bind_cmd(3'd1, 8'd255, 8'd2, 1'b1)));
        // zero length and out of range channels are refused
        plan.push_back(checked_row(bind_cmd(3'd2, 8'd9, 8'd0, 1'b1),
                                   reply_of(3'd2, 1'b0, 1'b0, 1'b0, 1'b0)));
        plan.push_back(checked_row(bind_cmd(3'd4, 8'd0, 8'd1, 1'b0),
                                   reply_of(3'd4, 1'b0, 1'b0, 1'b0, 1'b0)));
        plan.push_back(checked_row(bind_cmd(3'd7, 8'd0, 8'd255, 1'b1),
                                   reply_of(3'd7, 1'b0, 1'b0, 1'b0, 1'b0)));
        plan.push_back(cmd_row(tick_cmd(4'hF, 4'hF)));
        // failed staging on channel 0 leaves it unchanged
        plan.push_back(cmd_row(tick_cmd(4'hF, 4'hE)));
        plan.push_back(cmd_row(tick_cmd(4'hF, 4'hF)));
        plan.push_back(cmd_row(simple_cmd(OP_QUERY, 3'd0, 4'hF)));
        // permission withdrawn from channel 0 interrupts it
        plan.push_back(cmd_row(tick_cmd(4'hE, 4'hF)));
        plan.push_back(checked_row(simple_cmd(OP_TAKE, 3'd0, 4'hF),
                                   reply_of(3'd0, 1'b1, 1'b0, 1'b0, 1'b1)));
        plan.push_back(checked_row(simple_cmd(OP_TAKE, 3'd0, 4'hF),
                                   reply_of(3'd0, 1'b1, 1'b0, 1'b0, 1'b0)));
        plan.push_back(checked_row(simple_cmd(OP_UNBIND, 3'd1, 4'hF),
                                   reply_of(3'd1, 1'b1, 1'b0, 1'b0, 1'b0)));
        plan.push_back(checked_row(simple_cmd(OP_UNBIND, 3'd5, 4'hF),
                                   reply_of(3'd5, 1'b0, 1'b0, 1'b0, 1'b0)));
        plan.push_back(checked_row(simple_cmd(OP_TAKE, 3'd6, 4'hF),
                                   reply_of(3'd6, 1'b0, 1'b0, 1'b0, 1'b0)));
        plan.push_back(checked_row(simple_cmd(OP_QUERY, 3'd4, 4'hF),
                                   reply_of(3'd4, 1'b0, 1'b0, 1'b0, 1'b0)));
        plan.push_back(host_row(1'b0));

        foreach (plan[i])
        begin
            cur = plan[i];
            if (cur.set_host)
            begin
                drain_results();
                write_host(cur.host_val);
            end
            else
            begin
                issue(cur.cmd, cur.typed, cur.want);
            end
        end

        drain_results();
        write_host(1'b1);

        // random part: mostly ticks over bound animations, with binds kept
        // to written table ranges and some noise mixed in
        while (random_items < RANDOM_ITEMS)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 2)
            begin
                drain_results();
                write_host(1'($urandom_range(0, 3) != 0));
                continue;
            end
            if (roll < 4)
            begin
                // sender holds off until everything owed has come back
                drain_results();
            end
            w  = IN_BITS'({$urandom, $urandom});
            ch = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(4, 7))
                                             : 3'($urandom_range(0, 3));
            roll = $urandom_range(0, 99);
            if (roll < 50)
            begin
                w.operation = OP_TICK;
                if ($urandom_range(0, 4) != 0)
                begin
                    w.can_present_mask = 4'hF;
                end
                if ($urandom_range(0, 4) != 0)
                begin
                    w.stage_ok_mask = 4'hF;
                end
            end
            else if (roll < 66)
            begin
                roll = $urandom_range(0, 19);
                if (roll == 0)
                begin
                    count = 8'd0;
                end
                else if (roll == 1)
                begin
                    count = 8'd255;
                end
                else if (roll == 2)
                begin
                    count = 8'($urandom_range(0, 255));
                end
                else
                begin
                    count = 8'($urandom_range(1, 4));
                end
                ensure_loaded(w.frame_base, count);
                w.operation   = OP_BIND;
                w.battler     = ch;
                w.frame_count = count;
            end
            else if (roll < 76)
            begin
                w.operation = OP_LOAD;
                if ($urandom_range(0, 9) < 7)
                begin
                    w.duration_value = 16'($urandom_range(0, 3));
                end
            end
            else if (roll < 84)
            begin
                w.operation = OP_QUERY;
                w.battler   = ch;
            end
            else if (roll < 91)
            begin
                w.operation = OP_TAKE;
                w.battler   = ch;
            end
            else if (roll < 96)
            begin
                w.operation = OP_UNBIND;
                w.battler   = ch;
            end
            else
            begin
                w.operation = ($urandom_range(0, 1) != 0) ? OP_BAD_HI : OP_BAD_LO;
            end
            issue(w, 1'b0, '0);
            // a tick with the host detached is simply ignored
            if (!(w.operation == OP_TICK && !host_on))
            begin
                random_items++;
            end
        end

        drain_results();
        $display("ran %0d command words (%0d in the random part) under %0d host settings",
                 items_sent, random_items, host_writes);
        $display("checked %0d present words and %0d reply words", presents_seen, replies_seen);
        if (failures == 0)
        begin
            $display("sprite_frame_sequencer test passed");
        end
        else
        begin
            $display("sprite_frame_sequencer test failed");
        end
        $finish;
    end

    // watchdog far beyond the slowest correct run
    initial
    begin
        #5000000;
        $display("sprite_frame_sequencer test failed");
        $finish;
    end

endmodule
